[rtl/otcp_pkg.sv]
package otcp_pkg;

    // Field widths of the item ports
    localparam int FUNC_W   = 2;
    localparam int TS_W     = 48;
    localparam int OP_W     = 6;
    localparam int RIDX_W   = 7;
    localparam int OTIME_W  = 48;
    localparam int CNT_W    = 32;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OTHER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Per-stage control of one item in flight
    typedef struct packed {
        logic t_wr;    // charge elapsed ticks to a time bucket
        logic c_wr;    // bump an execution count
        logic rd;      // read request
        logic rd_ok;   // read index names an existing bucket
    } otcp_ctl_t;

endpackage

[rtl/opcode_time_and_count_profiler.sv]
// A read item passes from stage 1 to stage 2 and then into the output register.
// Throughput: one item per cycle unless stalled; the time and count buckets sit in two
// memories whose read-modify-write spans two stages, with one bypass register per memory.
// The input stalls only while a read result waits in the output register and the next
// read has reached the last stage. Reset (rst_n low, asynchronous) clears all control
// state and the bucket valid bits; every bucket reads as zero at once, no clearing pass.
module opcode_time_and_count_profiler #(
    parameter int OPCODE_COUNT = 64,
    parameter int TIME_BITS    = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [otcp_pkg::FUNC_W-1:0]  func,
    input  logic [otcp_pkg::TS_W-1:0]    timestamp,
    input  logic [otcp_pkg::OP_W-1:0]    opcode,
    input  logic [otcp_pkg::RIDX_W-1:0]  read_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [otcp_pkg::OTIME_W-1:0] bucket_time,
    output logic [otcp_pkg::CNT_W-1:0]   bucket_count
);
    import otcp_pkg::*;

    localparam int BUCKETS = OPCODE_COUNT + 1;
    localparam int BIDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SUM_W   = ((TIME_BITS > TS_W) ? TIME_BITS : TS_W) + 1;
    localparam logic [BIDX_W-1:0] NATIVE  = BIDX_W'(OPCODE_COUNT);
    localparam logic [SUM_W-1:0]  ACC_MAX = SUM_W'({TIME_BITS{1'b1}});

    // Event state
    logic                pending_valid_reg, pending_valid_next;
    logic [OP_W-1:0]     pending_opcode_reg, pending_opcode_next;
    logic [TS_W-1:0]     start_ticks_reg, start_ticks_next;
    logic                last_was_step_reg, last_was_step_next;
    logic                started_reg, started_next;

    // Stage 1: decoded item, memory addresses
    otcp_ctl_t           s1_ctl_reg, s1_ctl_next;
    logic [BIDX_W-1:0]   s1_t_addr_reg, s1_t_addr_next;
    logic [BIDX_W-1:0]   s1_c_addr_reg, s1_c_addr_next;
    logic [TS_W-1:0]     s1_d_reg, s1_d_next;

    // Stage 2: memory data in hand, update and respond
    otcp_ctl_t           s2_ctl_reg;
    logic [BIDX_W-1:0]   s2_t_addr_reg, s2_c_addr_reg;
    logic [TS_W-1:0]     s2_d_reg;
    logic [TIME_BITS-1:0] t_rdata_reg;
    logic [CNT_W-1:0]    c_rdata_reg;
    logic                t_rvld_reg, c_rvld_reg;
    logic                t_byp_reg, c_byp_reg;
    logic [TIME_BITS-1:0] t_byp_data_reg;
    logic [CNT_W-1:0]    c_byp_data_reg;

    // Bucket storage and their written flags
    logic [TIME_BITS-1:0] time_mem [BUCKETS];
    logic [CNT_W-1:0]     cnt_mem  [BUCKETS];
    logic [BUCKETS-1:0]   t_vld_reg, c_vld_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [OTIME_W-1:0]  bucket_time_reg;
    logic [CNT_W-1:0]    bucket_count_reg;

    logic                adv, acc, is_event, op_ok, rd_ok;
    logic                charge_pend, charge_nat;
    logic [TS_W-1:0]     elapsed;
    logic                t_we, c_we;
    logic [TIME_BITS-1:0] t_old, t_new;
    logic [CNT_W-1:0]    c_old, c_new;
    logic [SUM_W-1:0]    t_sum;
    logic [63:0]         t_old_wide;

    // Freeze only when a read in stage 2 cannot leave
    assign adv      = !(out_valid_reg && out_stall && s2_ctl_reg.rd);
    assign in_stall = !adv;
    assign acc      = in_valid && adv;

    // Decode the incoming item
    always_comb
    begin
        is_event    = (func == FUNC_STEP) || (func == FUNC_OTHER);
        op_ok       = 32'(opcode) < OPCODE_COUNT;
        rd_ok       = 32'(read_index) <= OPCODE_COUNT;
        elapsed     = (timestamp >= start_ticks_reg) ? (timestamp - start_ticks_reg) : '0;
        charge_pend = started_reg && pending_valid_reg;
        charge_nat  = (func == FUNC_OTHER) && started_reg && !last_was_step_reg;

        s1_ctl_next.t_wr  = acc && is_event && (charge_pend || charge_nat);
        s1_ctl_next.c_wr  = acc && (func == FUNC_STEP) && op_ok;
        s1_ctl_next.rd    = acc && (func == FUNC_READ);
        s1_ctl_next.rd_ok = rd_ok;
        s1_d_next         = elapsed;

        if (func == FUNC_READ)
        begin
            s1_t_addr_next = BIDX_W'(read_index);
            s1_c_addr_next = BIDX_W'(read_index);
        end
        else
        begin
            s1_t_addr_next = charge_pend ? BIDX_W'(pending_opcode_reg) : NATIVE;
            s1_c_addr_next = BIDX_W'(opcode);
        end
    end

    // Advance the event state on each accepted step or other event
    always_comb
    begin
        pending_valid_next  = pending_valid_reg;
        pending_opcode_next = pending_opcode_reg;
        start_ticks_next    = start_ticks_reg;
        last_was_step_next  = last_was_step_reg;
        started_next        = started_reg;
        if (acc && is_event)
        begin
            pending_valid_next = (func == FUNC_STEP) && op_ok;
            if ((func == FUNC_STEP) && op_ok)
            begin
                pending_opcode_next = opcode;
            end
            last_was_step_next = (func == FUNC_STEP);
            start_ticks_next   = timestamp;
            started_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg  <= 1'b0;
            pending_opcode_reg <= '0;
            start_ticks_reg    <= '0;
            last_was_step_reg  <= 1'b0;
            started_reg        <= 1'b0;
        end
        else
        begin
            pending_valid_reg  <= pending_valid_next;
            pending_opcode_reg <= pending_opcode_next;
            start_ticks_reg    <= start_ticks_next;
            last_was_step_reg  <= last_was_step_next;
            started_reg        <= started_next;
        end
    end

    // Stage control, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // Stage payload and bypass capture
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_t_addr_reg  <= s1_t_addr_next;
            s1_c_addr_reg  <= s1_c_addr_next;
            s1_d_reg       <= s1_d_next;
            s2_t_addr_reg  <= s1_t_addr_reg;
            s2_c_addr_reg  <= s1_c_addr_reg;
            s2_d_reg       <= s1_d_reg;
            t_rvld_reg     <= t_vld_reg[s1_t_addr_reg];
            c_rvld_reg     <= c_vld_reg[s1_c_addr_reg];
            t_byp_reg      <= t_we && (s2_t_addr_reg == s1_t_addr_reg);
            c_byp_reg      <= c_we && (s2_c_addr_reg == s1_c_addr_reg);
            t_byp_data_reg <= t_new;
            c_byp_data_reg <= c_new;
        end
    end

    // Bucket update in stage 2
    always_comb
    begin
        t_old = t_byp_reg ? t_byp_data_reg : (t_rvld_reg ? t_rdata_reg : '0);
        c_old = c_byp_reg ? c_byp_data_reg : (c_rvld_reg ? c_rdata_reg : '0);
        t_sum = SUM_W'(t_old) + SUM_W'(s2_d_reg);
        t_new = (t_sum > ACC_MAX) ? ACC_MAX[TIME_BITS-1:0] : t_sum[TIME_BITS-1:0];
        c_new = c_old + CNT_W'(1);
        t_we  = adv && s2_ctl_reg.t_wr;
        c_we  = adv && s2_ctl_reg.c_wr;
        t_old_wide = 64'(t_old);
    end

    // Bucket memories
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            time_mem[s2_t_addr_reg] <= t_new;
        end
        if (adv)
        begin
            t_rdata_reg <= time_mem[s1_t_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cnt_mem[s2_c_addr_reg] <= c_new;
        end
        if (adv)
        begin
            c_rdata_reg <= cnt_mem[s1_c_addr_reg];
        end
    end

    // Mark buckets once written; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_vld_reg <= '0;
            c_vld_reg <= '0;
        end
        else
        begin
            if (t_we)
            begin
                t_vld_reg[s2_t_addr_reg] <= 1'b1;
            end
            if (c_we)
            begin
                c_vld_reg[s2_c_addr_reg] <= 1'b1;
            end
        end
    end

    // Output register: load a read result, drop it once taken
    always_comb
    begin
        if (adv && s2_ctl_reg.rd)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_ctl_reg.rd)
        begin
            bucket_time_reg  <= s2_ctl_reg.rd_ok ? t_old_wide[OTIME_W-1:0] : '0;
            bucket_count_reg <= s2_ctl_reg.rd_ok ? c_old : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bucket_time  = bucket_time_reg;
    assign bucket_count = bucket_count_reg;

    // Checks
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && s2_ctl_reg.rd))
        else $error("input stalled without a blocked read");

    a_pending_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        pending_valid_reg |-> (last_was_step_reg && started_reg))
        else $error("opcode pending without a preceding step");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(s2_ctl_reg.rd && (s2_ctl_reg.t_wr || s2_ctl_reg.c_wr)))
        else $error("read item also updates a bucket");

    a_time_addr: assert property (@(posedge clk) disable iff (!rst_n)
        t_we |-> (s2_t_addr_reg <= NATIVE))
        else $error("time write beyond the native bucket");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_ctl_reg.rd) |=> out_valid_reg)
        else $error("read result not loaded");

endmodule

[tb/tb_opcode_time_and_count_profiler.sv]
module tb_opcode_time_and_count_profiler;

    import otcp_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int OPCODES        = 64;
    localparam int NATIVE_BUCKET  = OPCODES;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_CYCLES = 400000;

    // func code the block leaves unused; such items must be dropped
    localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
    localparam logic [TS_W-1:0]   TS_MAX       = '1;

    typedef struct {
        logic [OTIME_W-1:0] ticks;
        logic [CNT_W-1:0]   count;
    } bucket_t;

    // Mirror of the profiler buckets plus the queue of pending read results
    class bucket_ledger;
        logic [OTIME_W-1:0] acc_ticks [0:NATIVE_BUCKET];
        logic [CNT_W-1:0]   exec_cnt  [0:NATIVE_BUCKET];
        bit                 has_pending;
        logic [OP_W-1:0]    pending_op;
        logic [TS_W-1:0]    mark_ts;
        bit                 prev_was_step;
        bit                 seen_event;
        bucket_t            read_results [$];
        int errors, checked, saturations;
        int steps, others, reads, ignored;

        function new();
            foreach (acc_ticks[i])
            begin
                acc_ticks[i] = '0;
                exec_cnt[i]  = '0;
            end
            has_pending   = 0;
            pending_op    = '0;
            mark_ts       = '0;
            prev_was_step = 0;
            seen_event    = 0;
        endfunction

        // add clamped elapsed ticks to one bucket, saturating at all ones
        function void charge(int bucket, logic [TS_W-1:0] now);
            logic [TS_W-1:0]  elapsed;
            logic [OTIME_W:0] sum;
            elapsed = (now >= mark_ts) ? now - mark_ts : '0;
            sum = {1'b0, acc_ticks[bucket]} + {1'b0, elapsed};
            if (sum[OTIME_W])
            begin
                acc_ticks[bucket] = '1;
                saturations++;
            end
            else
                acc_ticks[bucket] = sum[OTIME_W-1:0];
        endfunction

        function void note_event(logic [FUNC_W-1:0] f, logic [TS_W-1:0] now,
                                 logic [OP_W-1:0] op, logic [RIDX_W-1:0] ridx);
            bucket_t res;
            case (f)
                FUNC_READ:
                begin
                    reads++;
                    if (ridx <= NATIVE_BUCKET)
                    begin
                        res.ticks = acc_ticks[ridx];
                        res.count = exec_cnt[ridx];
                    end
                    else
                    begin
                        res.ticks = '0;
                        res.count = '0;
                    end
                    read_results.push_back(res);
                end
                FUNC_STEP, FUNC_OTHER:
                begin
                    // close out the pending opcode first
                    if (seen_event && has_pending)
                        charge(int'(pending_op), now);
                    has_pending = 0;
                    if (f == FUNC_STEP)
                    begin
                        steps++;
                        exec_cnt[op] = exec_cnt[op] + CNT_W'(1);
                        pending_op    = op;
                        has_pending   = 1;
                        prev_was_step = 1;
                    end
                    else
                    begin
                        others++;
                        if (seen_event && !prev_was_step)
                            charge(NATIVE_BUCKET, now);
                        prev_was_step = 0;
                    end
                    mark_ts    = now;
                    seen_event = 1;
                end
                default:
                    ignored++;
            endcase
        endfunction

        function void check_bucket(logic [OTIME_W-1:0] t, logic [CNT_W-1:0] c);
            bucket_t want;
            if (read_results.size() == 0)
            begin
                $error("bucket result with no read outstanding: time %0h count %0h", t, c);
                errors++;
                return;
            end
            want = read_results.pop_front();
            checked++;
            if (t !== want.ticks)
            begin
                $error("bucket_time mismatch: expected %0h, actual %0h", want.ticks, t);
                errors++;
            end
            if (c !== want.count)
            begin
                $error("bucket_count mismatch: expected %0h, actual %0h", want.count, c);
                errors++;
            end
        endfunction

        function int outstanding();
            return read_results.size();
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func       = '0;
    logic [TS_W-1:0]     timestamp  = '0;
    logic [OP_W-1:0]     opcode     = '0;
    logic [RIDX_W-1:0]   read_index = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [OTIME_W-1:0]  bucket_time;
    logic [CNT_W-1:0]    bucket_count;

    bucket_ledger ledger = new();
    int burst_left      = 30;
    bit random_started  = 0;

    opcode_time_and_count_profiler #(
        .OPCODE_COUNT (OPCODES),
        .TIME_BITS    (48)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .timestamp    (timestamp),
        .opcode       (opcode),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bucket_time  (bucket_time),
        .bucket_count (bucket_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // check results first, then note the item accepted on the same edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_bucket(bucket_time, bucket_count);
        if (rst_n && in_valid && !in_stall)
            ledger.note_event(func, timestamp, opcode, read_index);
    end

    // Offer one item, hold it until accepted, then pace the next burst
    task automatic offer(input logic [FUNC_W-1:0] f, input logic [TS_W-1:0] ts,
                         input logic [OP_W-1:0] op, input logic [RIDX_W-1:0] ridx);
        in_valid   <= 1'b1;
        func       <= f;
        timestamp  <= ts;
        opcode     <= op;
        read_index <= ridx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // drop valid and scramble the idle payload during the gap
            in_valid   <= 1'b0;
            func       <= FUNC_W'($urandom);
            timestamp  <= TS_W'({$urandom, $urandom});
            opcode     <= OP_W'($urandom);
            read_index <= RIDX_W'($urandom);
            repeat ($urandom_range(1, 10))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Receiver: one long hold-off once random traffic runs, else stall segments
    initial
    begin : receiver
        int  seg_len;
        int  stall_pct;
        bit  held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            if (random_started && !held)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD)
                    @(posedge clk);
            end
            seg_len = $urandom_range(10, 150);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (seg_len)
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [TS_W-1:0]   clock_ts;
        logic [FUNC_W-1:0] f;
        logic [OP_W-1:0]   op;
        logic [RIDX_W-1:0] ridx;
        int                k;
        int                sent;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read buckets straight out of reset, including past the native bucket
        offer(FUNC_READ, '0, '0, '0);
        offer(FUNC_READ, '0, '0, RIDX_W'(NATIVE_BUCKET));
        offer(FUNC_READ, '0, '0, 7'h7F);
        // first event only marks the start; backward time clamps to zero
        offer(FUNC_STEP, 48'd100, 6'd5, '0);
        offer(FUNC_OTHER, 48'd50, '0, '0);
        offer(FUNC_OTHER, 48'd300, '0, '0);
        offer(FUNC_STEP, TS_MAX, 6'd63, '0);
        offer(FUNC_STEP, '0, 6'd0, '0);
        // full-range elapsed twice saturates opcode 0
        offer(FUNC_OTHER, TS_MAX, '0, '0);
        offer(FUNC_STEP, '0, 6'd0, '0);
        offer(FUNC_OTHER, TS_MAX, '0, '0);
        // same for the native bucket
        offer(FUNC_OTHER, '0, '0, '0);
        offer(FUNC_OTHER, TS_MAX, '0, '0);
        offer(FUNC_OTHER, '0, '0, '0);
        offer(FUNC_OTHER, TS_MAX, '0, '0);
        offer(FUNC_IGNORED, 48'h123, 6'd9, 7'd9);
        // reads right behind updates of the same bucket
        offer(FUNC_STEP, 48'd1000, 6'd5, '0);
        offer(FUNC_READ, '0, '0, 7'd5);
        offer(FUNC_STEP, 48'd1010, 6'd5, '0);
        offer(FUNC_READ, '0, '0, 7'd5);
        offer(FUNC_READ, '0, '0, 7'd0);
        offer(FUNC_READ, '0, '0, 7'd63);
        offer(FUNC_READ, '0, '0, RIDX_W'(NATIVE_BUCKET));
        offer(FUNC_READ, '0, '0, 7'd65);
        offer(FUNC_READ, '0, '0, 7'd100);

        // random traffic around a running tick counter
        random_started = 1;
        clock_ts = TS_W'({$urandom, $urandom});
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            k = $urandom_range(0, 99);
            if (k < 3)
                clock_ts = TS_W'({$urandom, $urandom});
            else if (k < 8)
                clock_ts = clock_ts - TS_W'($urandom_range(1, 5000));
            else if (k < 11)
                clock_ts = clock_ts + TS_W'($urandom);
            else
                clock_ts = clock_ts + TS_W'($urandom_range(0, 60));

            op = ($urandom_range(0, 1) == 0) ? OP_W'($urandom_range(0, 3))
                                             : OP_W'($urandom_range(0, 63));
            k = $urandom_range(0, 99);
            if (k < 10)
                ridx = RIDX_W'(NATIVE_BUCKET);
            else if (k < 18)
                ridx = RIDX_W'($urandom_range(NATIVE_BUCKET + 1, 127));
            else
                ridx = RIDX_W'(op);

            k = $urandom_range(0, 99);
            if (k < 45)
                f = FUNC_STEP;
            else if (k < 70)
                f = FUNC_OTHER;
            else if (k < 95)
                f = FUNC_READ;
            else
                f = FUNC_IGNORED;

            offer(f, clock_ts, op, ridx);
            if (f != FUNC_IGNORED)
                sent++;
        end
        in_valid <= 1'b0;

        // drain every read result, then watch for stray output
        while (ledger.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("run covered %0d step, %0d other, %0d read and %0d unused-code items",
                 ledger.steps, ledger.others, ledger.reads, ledger.ignored);
        $display("%0d bucket reads compared, %0d time charges hit saturation",
                 ledger.checked, ledger.saturations);
        if (ledger.errors == 0)
            $display("tb_opcode_time_and_count_profiler: clean");
        else
            $display("tb_opcode_time_and_count_profiler: errors");
        $finish;
    end

    // hard stop if the run hangs
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_opcode_time_and_count_profiler: errors");
        $finish;
    end

endmodule
